[hw/rtl/dhb_pkg.sv]
package dhb_pkg;

    // drive constants
    localparam int unsigned SPEED_LIMIT = 100;   // 1..127
    localparam int unsigned DUTY_FULL   = 255;   // 1..255
    localparam int unsigned DUTY_MAX    = 255;

    // field widths
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned MAG_W   = 7;
    localparam int unsigned DIVD_W  = 2 * DUTY_W;
    localparam int unsigned IN_W    = 32;
    localparam int unsigned OUT_W   = 24;

    // register reset values
    localparam logic [6:0] DEADBAND_RST   = 7'd10;
    localparam logic [7:0] RAMP_STEPS_RST = 8'd10;

    typedef enum logic [0:0] {
        CFG_DEADBAND   = 1'b0,
        CFG_RAMP_STEPS = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        FN_SET_SPEED = 3'd0,
        FN_RAW_LEFT  = 3'd1,
        FN_RAW_RIGHT = 3'd2,
        FN_RAMP_STOP = 3'd3,
        FN_ESTOP     = 3'd4,
        FN_TICK      = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        DIR_COAST = 2'b00,
        DIR_FWD   = 2'b01,
        DIR_REV   = 2'b11
    } dir_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

[hw/rtl/dual_hbridge_drive_with_ramp_stop.sv]
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    command word: speeds/raw in tdata, func in tuser
// m_        out  m_tvalid/m_tready    drive word, 24 bits
// cfg_      in   cfg_valid/cfg_ready  register index + 8-bit data
//
// One result word per command word; the next command is taken only after the
// previous result has been loaded into the output register and the FSM is idle.
// The bit-serial divider runs two divisions per word (left then right side),
// each with a load state before it and a store of the quotient when done.
// aresetn is synchronous: both sides coast, ramp cleared, registers to defaults.
// A stalled result holds in m_tdata; the next command is taken meanwhile but
// its result waits in the output stage until m_tready.
module dual_hbridge_drive_with_ramp_stop (
    input  logic        aclk,
    input  logic        aresetn,
    // {pad[31:29], raw_direction[28:27], raw_duty[26:16], right_speed[15:8],
    //  left_speed[7:0]}
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // {func[2:0]}
    input  logic [2:0]  s_tuser,
    // {pad[23:21], ramping[20], right_duty_out[19:12], left_duty_out[11:4],
    //  right_rev_pin[3], right_fwd_pin[2], left_rev_pin[1], left_fwd_pin[0]}
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    // config write port
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import dhb_pkg::*;

    // ---------------- state ----------------
    state_t            state_reg, state_next;
    logic              side_reg, side_next;       // 0 left, 1 right
    logic              spd_reg, spd_next;         // speed word pending divide

    logic [6:0]        deadband_reg, deadband_next;
    logic [7:0]        steps_reg, steps_next;

    logic [DUTY_W-1:0] lduty_reg, lduty_next, rduty_reg, rduty_next;
    dir_t              ldir_reg, ldir_next, rdir_reg, rdir_next;
    logic              ramp_on_reg, ramp_on_next;
    logic [7:0]        ridx_reg, ridx_next;
    logic [DUTY_W-1:0] lstart_reg, lstart_next, rstart_reg, rstart_next;
    logic [MAG_W-1:0]  lmag_reg, lmag_next, rmag_reg, rmag_next;
    logic [DUTY_W-1:0] ldisp_reg, ldisp_next, rdisp_reg, rdisp_next;

    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    // ---------------- control strobes ----------------
    logic in_acc, div_start, out_load;
    logic div_done;
    logic [DUTY_W-1:0] div_q;

    assign in_acc = s_tvalid && s_tready;

    // ---------------- input field decode ----------------
    func_t             fn;
    logic signed [7:0] lspd, rspd;
    logic signed [10:0] raw_d;
    logic [1:0]        raw_r;
    logic [DUTY_W-1:0] raw_duty_sat;
    dir_t              raw_dir;

    assign fn    = func_t'(s_tuser);
    assign lspd  = s_tdata[7:0];
    assign rspd  = s_tdata[15:8];
    assign raw_d = s_tdata[26:16];
    assign raw_r = s_tdata[28:27];

    // saturate to 0..255
    always_comb begin
        if (raw_d[10])
            raw_duty_sat = '0;
        else if (raw_d[9:8] != 2'b00)
            raw_duty_sat = DUTY_MAX[DUTY_W-1:0];
        else
            raw_duty_sat = raw_d[7:0];
    end

    // either negative code is reverse
    assign raw_dir = raw_r[1] ? DIR_REV : (raw_r[0] ? DIR_FWD : DIR_COAST);

    // speed -> direction and clamped, deadbanded magnitude
    function automatic dir_t spd_dir(input logic signed [7:0] s);
        if (s[7])
            return DIR_REV;
        else if (s != 8'sd0)
            return DIR_FWD;
        else
            return DIR_COAST;
    endfunction

    function automatic logic [MAG_W-1:0] spd_mag(input logic signed [7:0] s,
                                                input logic [6:0] db);
        logic [7:0] a;
        logic [7:0] c;
        a = s[7] ? (8'd0 - s) : s;           // -128 -> 128, fine unsigned
        c = (a > SPEED_LIMIT[7:0]) ? SPEED_LIMIT[7:0] : a;
        if (c < {1'b0, db})
            return '0;
        else
            return c[MAG_W-1:0];
    endfunction

    logic [7:0] n_eff;
    assign n_eff = (steps_reg == 8'd0) ? 8'd1 : steps_reg;

    // ---------------- divider operands ----------------
    // ramp: start*(N-k)/N ; speed: mag*DUTY_FULL/SPEED_LIMIT ; else duty/1
    logic [DUTY_W-1:0] op_start, op_duty;
    logic [MAG_W-1:0]  op_mag;
    logic [7:0]        op_fac;
    logic [DIVD_W-1:0] op_dividend;
    logic [7:0]        op_divisor;

    assign op_start = side_reg ? rstart_reg : lstart_reg;
    assign op_duty  = side_reg ? rduty_reg  : lduty_reg;
    assign op_mag   = side_reg ? rmag_reg   : lmag_reg;
    assign op_fac   = (ridx_reg >= n_eff) ? 8'd0 : (n_eff - ridx_reg);

    // products formed at full dividend width
    always_comb begin
        if (ramp_on_reg) begin
            op_dividend = {{DUTY_W{1'b0}}, op_start} * {{DUTY_W{1'b0}}, op_fac};
            op_divisor  = n_eff;
        end else if (spd_reg) begin
            op_dividend = {{(DIVD_W-MAG_W){1'b0}}, op_mag} * DIVD_W'(DUTY_FULL);
            op_divisor  = SPEED_LIMIT[7:0];
        end else begin
            op_dividend = {{DUTY_W{1'b0}}, op_duty};
            op_divisor  = 8'd1;
        end
    end

    dhb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (op_dividend),
        .divisor  (op_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---------------- FSM outputs ----------------
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_LOAD: div_start = 1'b1;
            ST_OUT:  out_load  = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    // ---------------- FSM next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = side_reg ? ST_OUT : ST_LOAD;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb begin
        side_next     = side_reg;
        spd_next      = spd_reg;
        deadband_next = deadband_reg;
        steps_next    = steps_reg;
        lduty_next    = lduty_reg;
        rduty_next    = rduty_reg;
        ldir_next     = ldir_reg;
        rdir_next     = rdir_reg;
        ramp_on_next  = ramp_on_reg;
        ridx_next     = ridx_reg;
        lstart_next   = lstart_reg;
        rstart_next   = rstart_reg;
        lmag_next     = lmag_reg;
        rmag_next     = rmag_reg;
        ldisp_next    = ldisp_reg;
        rdisp_next    = rdisp_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_DEADBAND:   deadband_next = cfg_data[6:0];
                CFG_RAMP_STEPS: steps_next    = cfg_data;
                default: ;
            endcase
        end

        if (in_acc) begin
            side_next = 1'b0;
            spd_next  = 1'b0;
            case (fn)
                FN_SET_SPEED: if (!ramp_on_reg) begin
                    spd_next  = 1'b1;
                    ldir_next = spd_dir(lspd);
                    rdir_next = spd_dir(rspd);
                    lmag_next = spd_mag(lspd, deadband_reg);
                    rmag_next = spd_mag(rspd, deadband_reg);
                end
                FN_RAW_LEFT: if (!ramp_on_reg) begin
                    lduty_next = raw_duty_sat;
                    ldir_next  = raw_dir;
                end
                FN_RAW_RIGHT: if (!ramp_on_reg) begin
                    rduty_next = raw_duty_sat;
                    rdir_next  = raw_dir;
                end
                FN_RAMP_STOP: if (!ramp_on_reg) begin
                    ramp_on_next = 1'b1;
                    ridx_next    = 8'd0;
                    lstart_next  = lduty_reg;
                    rstart_next  = rduty_reg;
                end
                FN_ESTOP: begin
                    lduty_next   = '0;
                    rduty_next   = '0;
                    ldir_next    = DIR_COAST;
                    rdir_next    = DIR_COAST;
                    ramp_on_next = 1'b0;
                    ridx_next    = 8'd0;
                end
                FN_TICK: if (ramp_on_reg) begin
                    if (ridx_reg >= n_eff) begin
                        // past the last step: coast both sides
                        lduty_next   = '0;
                        rduty_next   = '0;
                        ldir_next    = DIR_COAST;
                        rdir_next    = DIR_COAST;
                        ramp_on_next = 1'b0;
                        ridx_next    = 8'd0;
                    end else begin
                        ridx_next = ridx_reg + 8'd1;
                    end
                end
                default: ;
            endcase
        end

        // store quotient for the side just divided
        if (state_reg == ST_DIV && div_done) begin
            if (side_reg) begin
                rdisp_next = div_q;
                if (spd_reg) rduty_next = div_q;
            end else begin
                ldisp_next = div_q;
                if (spd_reg) lduty_next = div_q;
                side_next = 1'b1;
            end
        end

        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {3'b000,
                            ramp_on_reg,
                            (rdir_reg == DIR_COAST) ? {DUTY_W{1'b0}} : rdisp_reg,
                            (ldir_reg == DIR_COAST) ? {DUTY_W{1'b0}} : ldisp_reg,
                            rdir_reg == DIR_REV,
                            rdir_reg == DIR_FWD,
                            ldir_reg == DIR_REV,
                            ldir_reg == DIR_FWD};
        end
    end

    always_ff @(posedge aclk) begin
        lmag_reg   <= lmag_next;
        rmag_reg   <= rmag_next;
        ldisp_reg  <= ldisp_next;
        rdisp_reg  <= rdisp_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            side_reg     <= 1'b0;
            spd_reg      <= 1'b0;
            deadband_reg <= DEADBAND_RST;
            steps_reg    <= RAMP_STEPS_RST;
            lduty_reg    <= '0;
            rduty_reg    <= '0;
            ldir_reg     <= DIR_COAST;
            rdir_reg     <= DIR_COAST;
            ramp_on_reg  <= 1'b0;
            ridx_reg     <= 8'd0;
            lstart_reg   <= '0;
            rstart_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            side_reg     <= side_next;
            spd_reg      <= spd_next;
            deadband_reg <= deadband_next;
            steps_reg    <= steps_next;
            lduty_reg    <= lduty_next;
            rduty_reg    <= rduty_next;
            ldir_reg     <= ldir_next;
            rdir_reg     <= rdir_next;
            ramp_on_reg  <= ramp_on_next;
            ridx_reg     <= ridx_next;
            lstart_reg   <= lstart_next;
            rstart_reg   <= rstart_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

endmodule

[hw/rtl/dhb_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Caller guarantees the quotient fits in DUTY_W bits.
module dhb_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [7:0]  quotient
);
    import dhb_pkg::*;

    logic [DUTY_W:0]   rem_reg, rem_next;
    logic [DUTY_W-1:0] lo_reg, lo_next;
    logic [DUTY_W-1:0] dsr_reg, dsr_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DUTY_W:0]   trial;
    logic              fits;

    // shift in next dividend bit, try the subtract
    assign trial = {rem_reg[DUTY_W-1:0], lo_reg[DUTY_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = {1'b0, dividend[DIVD_W-1:DUTY_W]};
            lo_next   = dividend[DUTY_W-1:0];
            dsr_next  = divisor;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? (trial - {1'b0, dsr_reg}) : trial;
            lo_next  = {lo_reg[DUTY_W-2:0], fits};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import dhb_pkg::*;

    // func codes the block leaves unused; they must come back as a no-op word
    localparam logic [2:0] FN_UNUSED_A = 3'd6;
    localparam logic [2:0] FN_UNUSED_B = 3'd7;

    localparam int CLK_HALF     = 4;
    localparam int NUM_PHASES   = 13;
    localparam int PHASE_WORDS  = 150;
    localparam int MAX_REPORTS  = 10;
    // longest quiet stretch of a correct run is a sender gap, the divider run
    // of one command word and a receiver stall added together
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 30;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    dual_hbridge_drive_with_ramp_stop uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // one drive word as it appears on m_tdata
    typedef struct {
        logic       left_fwd;
        logic       left_rev;
        logic       right_fwd;
        logic       right_rev;
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        logic       ramping;
    } drive_t;

    // ------------------------------------------------------------------
    // Drive predictor and expected-word store. Holds its own copy of the
    // bridge state and both registers; every accepted command word adds
    // exactly one expected drive word.
    // ------------------------------------------------------------------
    class drive_scoreboard;
        drive_t      expected_drive[$];
        int          errors;
        int          checked;

        logic [6:0]  db_reg;
        logic [7:0]  steps_reg;
        logic [7:0]  left_duty;
        logic [7:0]  right_duty;
        dir_t        left_dir;
        dir_t        right_dir;
        logic        ramp_on;
        int unsigned ramp_idx;
        logic [7:0]  left_start;
        logic [7:0]  right_start;

        function new();
            errors      = 0;
            checked     = 0;
            db_reg      = DEADBAND_RST;
            steps_reg   = RAMP_STEPS_RST;
            left_start  = '0;
            right_start = '0;
            coast_both();
        endfunction

        function void coast_both();
            left_duty  = '0;
            right_duty = '0;
            left_dir   = DIR_COAST;
            right_dir  = DIR_COAST;
            ramp_on    = 1'b0;
            ramp_idx   = 0;
        endfunction

        function int unsigned steps_eff();
            return (steps_reg == 0) ? 1 : steps_reg;
        endfunction

        function void write_reg(input cfg_index_t idx, input logic [7:0] v);
            if (idx == CFG_DEADBAND)
                db_reg = v[6:0];
            else
                steps_reg = v;
        endfunction

        // clamp to +-limit, sign -> direction, deadband, scale to 0..255
        function void speed_to_drive(input logic signed [7:0] s,
                                     output logic [7:0] duty, output dir_t dir);
            int          v;
            int unsigned mag;
            v = int'(s);
            if (v > int'(SPEED_LIMIT))  v = int'(SPEED_LIMIT);
            if (v < -int'(SPEED_LIMIT)) v = -int'(SPEED_LIMIT);
            dir = (v > 0) ? DIR_FWD : ((v < 0) ? DIR_REV : DIR_COAST);
            mag = (v < 0) ? -v : v;
            if (mag < db_reg)
                duty = '0;
            else
                duty = 8'((mag * DUTY_FULL) / SPEED_LIMIT);
        endfunction

        // saturate duty to 0..255; any negative direction (incl. -2) is reverse
        function void raw_to_drive(input logic [10:0] d_raw, input logic [1:0] dir_raw,
                                   output logic [7:0] duty, output dir_t dir);
            int d;
            int r;
            d = int'($signed(d_raw));
            r = int'($signed(dir_raw));
            if (d < 0) d = 0;
            if (d > int'(DUTY_MAX)) d = int'(DUTY_MAX);
            duty = 8'(d);
            dir  = (r > 0) ? DIR_FWD : ((r < 0) ? DIR_REV : DIR_COAST);
        endfunction

        // step k of N drives floor(start*(N-k)/N); N read live
        function logic [7:0] ramp_level(input logic [7:0] start);
            int unsigned n;
            n = steps_eff();
            if (ramp_idx >= n) return '0;
            return 8'((start * (n - ramp_idx)) / n);
        endfunction

        function void predict_drive(input logic [31:0] w);
            drive_t     d;
            logic [7:0] ld;
            logic [7:0] rd;
            case (w[2:0])
                FN_SET_SPEED: if (!ramp_on) begin
                    speed_to_drive(w[10:3], left_duty, left_dir);
                    speed_to_drive(w[18:11], right_duty, right_dir);
                end
                FN_RAW_LEFT:  if (!ramp_on) raw_to_drive(w[29:19], w[31:30], left_duty, left_dir);
                FN_RAW_RIGHT: if (!ramp_on) raw_to_drive(w[29:19], w[31:30], right_duty, right_dir);
                FN_RAMP_STOP: if (!ramp_on) begin
                    ramp_on     = 1'b1;
                    ramp_idx    = 0;
                    left_start  = left_duty;
                    right_start = right_duty;
                end
                FN_ESTOP: coast_both();
                FN_TICK: if (ramp_on) begin
                    if (ramp_idx >= steps_eff())
                        coast_both();
                    else
                        ramp_idx++;
                end
                default: ;
            endcase

            if (ramp_on) begin
                ld = ramp_level(left_start);
                rd = ramp_level(right_start);
            end else begin
                ld = left_duty;
                rd = right_duty;
            end
            d.left_fwd   = (left_dir == DIR_FWD);
            d.left_rev   = (left_dir == DIR_REV);
            d.right_fwd  = (right_dir == DIR_FWD);
            d.right_rev  = (right_dir == DIR_REV);
            d.left_duty  = (left_dir == DIR_COAST) ? 8'd0 : ld;
            d.right_duty = (right_dir == DIR_COAST) ? 8'd0 : rd;
            d.ramping    = ramp_on;
            expected_drive.push_back(d);
        endfunction

        function void check_drive(input logic [23:0] w);
            drive_t got;
            drive_t exp_d;
            got.left_fwd   = w[0];
            got.left_rev   = w[1];
            got.right_fwd  = w[2];
            got.right_rev  = w[3];
            got.left_duty  = w[11:4];
            got.right_duty = w[19:12];
            got.ramping    = w[20];
            checked++;
            if (expected_drive.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] drive word %h with nothing expected", $realtime, w);
                return;
            end
            exp_d = expected_drive.pop_front();
            if (got.left_fwd !== exp_d.left_fwd || got.left_rev !== exp_d.left_rev ||
                got.right_fwd !== exp_d.right_fwd || got.right_rev !== exp_d.right_rev ||
                got.left_duty !== exp_d.left_duty || got.right_duty !== exp_d.right_duty ||
                got.ramping !== exp_d.ramping) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("[%0t] drive word %0d mismatch", $realtime, checked);
                    $display("  expected L fwd/rev %b%b duty %0d  R fwd/rev %b%b duty %0d  ramp %b",
                             exp_d.left_fwd, exp_d.left_rev, exp_d.left_duty,
                             exp_d.right_fwd, exp_d.right_rev, exp_d.right_duty, exp_d.ramping);
                    $display("  actual   L fwd/rev %b%b duty %0d  R fwd/rev %b%b duty %0d  ramp %b",
                             got.left_fwd, got.left_rev, got.left_duty,
                             got.right_fwd, got.right_rev, got.right_duty, got.ramping);
                end
            end
        endfunction

        function int outstanding();
            return expected_drive.size();
        endfunction
    endclass

    drive_scoreboard sb;

    // stimulus bookkeeping
    int unsigned cur_steps;      // live ramp_steps, for sizing tick runs
    int          ticks_left;     // ticks still wanted for the ramp in flight
    bit          tx_burst;       // phase with no sender gaps
    bit          rx_burst;       // phase with no receiver stalls
    int          words_sent;
    int          ticks_sent;
    int          stops_sent;
    int          settings_used;
    int          quiet_cycles;

    // clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // watchdog: ends the run when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles, %0d words outstanding",
                     $realtime, STALL_LIMIT, sb.outstanding());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: after each drive word, drop m_tready for a random hold that counts
    // down only while m_tvalid is high; in burst phases m_tready just stays high
    initial begin
        int hold;
        hold = 0;
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_drive(m_tdata);
                hold = rx_burst ? 0 : $urandom_range(0, 7);
                if (hold != 0) m_tready <= 1'b0;
            end else if (!m_tready && m_tvalid) begin
                hold--;
                if (hold <= 0) m_tready <= 1'b1;
            end
        end
    end

    // command: {raw_direction, raw_duty, right_speed, left_speed, func};
    // func goes out on tuser, the rest on tdata from bit 0 up
    function automatic logic [31:0] pack_cmd(input logic [2:0] f, input logic [7:0] ls,
                                             input logic [7:0] rs, input logic [10:0] duty,
                                             input logic [1:0] dir);
        return {dir, duty, rs, ls, f};
    endfunction

    // one command word; called at a clock edge, returns at its accept edge
    task automatic send_cmd(input logic [31:0] w);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w[2:0];
        s_tdata  <= {3'b000, w[31:3]};
        do @(posedge aclk); while (!s_tready);
        sb.predict_drive(w);
        words_sent++;
        if (w[2:0] == FN_TICK) ticks_sent++;
        if (w[2:0] == FN_RAMP_STOP) stops_sent++;
    endtask

    // sender holds off until every expected drive word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // both registers back to back; valid stays high across the two words
    task automatic set_registers(input logic [6:0] db, input logic [7:0] steps);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEADBAND;
        cfg_data  <= {1'b0, db};
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(CFG_DEADBAND, {1'b0, db});
        cfg_index <= CFG_RAMP_STEPS;
        cfg_data  <= steps;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(CFG_RAMP_STEPS, steps);
        cfg_valid <= 1'b0;
        cur_steps = (steps == 0) ? 1 : steps;
        settings_used++;
    endtask

    function automatic logic [10:0] rand_duty();
        return ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 255)) : 11'($urandom);
    endfunction

    function automatic logic [31:0] rand_setup();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return pack_cmd(FN_SET_SPEED, 8'($urandom), 8'($urandom), 11'($urandom),
                            2'($urandom));
        return pack_cmd((r == 1) ? FN_RAW_LEFT : FN_RAW_RIGHT, 8'($urandom), 8'($urandom),
                        rand_duty(), 2'($urandom));
    endfunction

    // Mostly well-formed drive/ramp sequences: set-up words, a ramp stop, then
    // the N ticks plus the closing one, sometimes one more. Noise and broken ramps mixed in.
    function automatic logic [31:0] next_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (ticks_left > 0) begin
            if (r < 85) begin
                ticks_left--;
                return pack_cmd(FN_TICK, 8'($urandom), 8'($urandom), 11'($urandom),
                                2'($urandom));
            end
            if (r < 91) return rand_setup();           // ignored mid-ramp
            if (r < 95) return pack_cmd(FN_RAMP_STOP, 8'($urandom), 8'($urandom),
                                        11'($urandom), 2'($urandom));
            if (r < 97) begin
                ticks_left = 0;                        // emergency stop cuts the ramp
                return pack_cmd(FN_ESTOP, 8'($urandom), 8'($urandom), 11'($urandom),
                                2'($urandom));
            end
            return $urandom;
        end
        if (r < 12) return $urandom;                   // any func, incl. unused codes
        if (r < 70) return rand_setup();
        if (r < 85) begin
            ticks_left = cur_steps + 1 + $urandom_range(0, 1);
            return pack_cmd(FN_RAMP_STOP, 8'($urandom), 8'($urandom), 11'($urandom),
                            2'($urandom));
        end
        if (r < 92) return pack_cmd(FN_TICK, 8'($urandom), 8'($urandom), 11'($urandom),
                                    2'($urandom));
        return pack_cmd(FN_ESTOP, 8'($urandom), 8'($urandom), 11'($urandom), 2'($urandom));
    endfunction

    initial begin
        int db;
        int st;
        sb            = new();
        cur_steps     = RAMP_STEPS_RST;
        ticks_left    = 0;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;
        words_sent    = 0;
        ticks_sent    = 0;
        stops_sent    = 0;
        settings_used = 0;
        quiet_cycles  = 0;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DEADBAND;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed: reset registers (deadband 10) ---
        send_cmd(pack_cmd(FN_SET_SPEED, 8'(127), 8'(-128), '0, '0));  // both clamp
        send_cmd(pack_cmd(FN_SET_SPEED, 8'(100), 8'(-100), '0, '0));  // exactly at limit
        send_cmd(pack_cmd(FN_SET_SPEED, 8'(9), 8'(-9), '0, '0));      // just under deadband
        send_cmd(pack_cmd(FN_SET_SPEED, 8'(10), 8'(-10), '0, '0));    // at deadband
        send_cmd(pack_cmd(FN_SET_SPEED, 8'(0), 8'(0), '0, '0));       // zero -> coast
        send_cmd(pack_cmd(FN_SET_SPEED, 8'(1), 8'(-1), '0, '0));
        send_cmd(pack_cmd(FN_RAW_LEFT, '0, '0, 11'(1023), 2'(1)));    // saturates high
        send_cmd(pack_cmd(FN_RAW_LEFT, '0, '0, 11'(-1024), 2'(-2)));  // -2 is reverse
        send_cmd(pack_cmd(FN_RAW_RIGHT, '0, '0, 11'(256), 2'(-1)));
        send_cmd(pack_cmd(FN_RAW_RIGHT, '0, '0, 11'(0), 2'(0)));
        send_cmd(pack_cmd(FN_SET_SPEED, 8'(55), 8'(-77), '0, '0));

        // short ramp so the whole stop fits in a few words
        drain();
        set_registers(DEADBAND_RST, 8'd2);
        send_cmd(pack_cmd(FN_RAMP_STOP, '0, '0, '0, '0));             // holds start duties
        send_cmd(pack_cmd(FN_SET_SPEED, 8'(100), 8'(100), '0, '0));   // ignored in ramp
        send_cmd(pack_cmd(FN_RAW_LEFT, '0, '0, 11'(200), 2'(1)));     // ignored in ramp
        send_cmd(pack_cmd(FN_RAMP_STOP, '0, '0, '0, '0));             // ignored in ramp
        send_cmd(pack_cmd(FN_TICK, '0, '0, '0, '0));
        send_cmd(pack_cmd(FN_TICK, '0, '0, '0, '0));
        send_cmd(pack_cmd(FN_TICK, '0, '0, '0, '0));                  // ends the ramp
        send_cmd(pack_cmd(FN_TICK, '0, '0, '0, '0));                  // no ramp: no change
        send_cmd(pack_cmd(FN_SET_SPEED, 8'(-60), 8'(80), '0, '0));
        send_cmd(pack_cmd(FN_ESTOP, '0, '0, '0, '0));
        send_cmd(pack_cmd(FN_UNUSED_A, 8'hff, 8'hff, 11'h7ff, 2'h3));
        send_cmd(pack_cmd(FN_UNUSED_B, 8'hff, 8'hff, 11'h7ff, 2'h3));

        // --- random phases; each starts from a full drain, which is also the
        // hold-off until all drive words are back. A phase may end mid-ramp,
        // so the next step count takes effect on a live ramp. ---
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0:       begin db = 0;   st = 0;   end
                1:       begin db = 100; st = 255; end
                2:       begin db = 10;  st = 10;  end
                3:       begin db = 0;   st = 1;   end
                4:       begin db = 100; st = 2;   end
                default: begin
                    db = $urandom_range(0, 100);
                    st = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 12);
                end
            endcase
            set_registers(7'(db), 8'(st));
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            repeat (PHASE_WORDS) send_cmd(next_cmd());
        end

        drain();
        repeat (SETTLE_TICKS) @(posedge aclk);

        $display("Covered %0d command words (%0d ramp stops, %0d ticks), %0d drive words,",
                 words_sent, stops_sent, ticks_sent, sb.checked);
        $display("  %0d register settings incl. deadband 0/100 and step counts 0/1/255",
                 settings_used);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d drive words missing", sb.errors, sb.outstanding());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
